// ===== design/mbet_pkg.sv =====
package mbet_pkg;

    localparam int CFG_ADDR_W = 4;

    typedef struct packed {
        logic [9:0] pixel_col;
        logic [9:0] pixel_row;
    } t_pixel;

    typedef struct packed {
        logic [15:0] iter_count;
        logic        in_set;
    } t_result;

    typedef struct packed {
        logic signed [31:0] center_real;
        logic signed [31:0] center_imag;
        logic        [30:0] pixel_step;
        logic        [15:0] iteration_limit;
    } t_cfg;

    typedef struct packed {
        logic load_pixel;
        logic map_mul;
        logic map_sum;
        logic iter_mul;
        logic iter_upd;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic at_limit;
        logic in_radius;
    } t_status;

endpackage

// ===== design/mandelbrot_escape_time_pixel_unit.sv =====
// Each pixel is loaded, mapped to c, iterated in the ITER_MUL/ITER_TEST loop, then
// written to the result register once it is free; the number of z updates made for
// the pixel is at most the iteration limit. One pixel is processed at a time, and a
// new pixel is taken while a result waits.
// Reset is synchronous and active low; it restores the register defaults and
// empties the result register.
module mandelbrot_escape_time_pixel_unit #(
    parameter int IMAGE_WIDTH  = 800,
    parameter int IMAGE_HEIGHT = 600,
    parameter int FRAC_BITS    = 28
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mbet_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  logic                            i_pixel_valid,
    output logic                            o_pixel_ready,
    input  mbet_pkg::t_pixel                i_pixel,
    output logic                            o_result_valid,
    input  logic                            i_result_ready,
    output mbet_pkg::t_result               o_result
);
    import mbet_pkg::*;

    t_cfg    cfg;
    t_cmd    cmd;
    t_status status;

    mbet_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mbet_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pixel_valid  (i_pixel_valid),
        .o_pixel_ready  (o_pixel_ready),
        .o_result_valid (o_result_valid),
        .i_result_ready (i_result_ready),
        .i_status       (status),
        .o_cmd          (cmd)
    );

    mbet_datapath #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT),
        .FRAC_BITS    (FRAC_BITS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_cmd    (cmd),
        .i_cfg    (cfg),
        .i_pixel  (i_pixel),
        .o_status (status),
        .o_result (o_result)
    );

endmodule

// ===== design/mbet_cfg.sv =====
module mbet_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mbet_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output mbet_pkg::t_cfg                 o_cfg
);
    import mbet_pkg::*;

    localparam logic [1:0] REG_CENTER_REAL = 2'd0;
    localparam logic [1:0] REG_CENTER_IMAG = 2'd1;
    localparam logic [1:0] REG_PIXEL_STEP  = 2'd2;
    localparam logic [1:0] REG_ITER_LIMIT  = 2'd3;

    localparam logic signed [31:0] RST_CENTER_REAL = -32'sd134217728;
    localparam logic signed [31:0] RST_CENTER_IMAG = 32'sd0;
    localparam logic [30:0]        RST_PIXEL_STEP  = 31'd1342177;
    localparam logic [15:0]        RST_ITER_LIMIT  = 16'd1000;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_real     <= RST_CENTER_REAL;
            r_cfg.center_imag     <= RST_CENTER_IMAG;
            r_cfg.pixel_step      <= RST_PIXEL_STEP;
            r_cfg.iteration_limit <= RST_ITER_LIMIT;
        end else if (wr_en) begin
            case (reg_idx)
                REG_CENTER_REAL: r_cfg.center_real     <= $signed(pwdata);
                REG_CENTER_IMAG: r_cfg.center_imag     <= $signed(pwdata);
                REG_PIXEL_STEP:  r_cfg.pixel_step      <= pwdata[30:0];
                REG_ITER_LIMIT:  r_cfg.iteration_limit <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_CENTER_REAL: prdata = r_cfg.center_real;
            REG_CENTER_IMAG: prdata = r_cfg.center_imag;
            REG_PIXEL_STEP:  prdata = {1'b0, r_cfg.pixel_step};
            REG_ITER_LIMIT:  prdata = {16'd0, r_cfg.iteration_limit};
            default:         prdata = 32'd0;
        endcase
    end

endmodule

// ===== design/mbet_datapath.sv =====
module mbet_datapath #(
    parameter int IMAGE_WIDTH  = 800,
    parameter int IMAGE_HEIGHT = 600,
    parameter int FRAC_BITS    = 28
) (
    input  logic              i_clk,
    input  mbet_pkg::t_cmd    i_cmd,
    input  mbet_pkg::t_cfg    i_cfg,
    input  mbet_pkg::t_pixel  i_pixel,
    output mbet_pkg::t_status o_status,
    output mbet_pkg::t_result o_result
);
    import mbet_pkg::*;

    localparam int          OFF_W      = 14;
    localparam int          PROD_W     = OFF_W + 32;
    localparam logic        ESC_ALWAYS = (2 * FRAC_BITS + 2 >= 64);
    localparam logic [63:0] ESC_THRESH = 64'd4 << (2 * FRAC_BITS);

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            return -32'sh8000_0000;
        end else begin
            return v[31:0];
        end
    endfunction

    logic signed [OFF_W-1:0]  r_dr, r_di;
    logic signed [PROD_W-1:0] r_offr, r_offi;
    logic signed [31:0]       r_cr, r_ci, r_zr, r_zi;
    logic signed [63:0]       r_sq_rr, r_sq_ii, r_pr_ri;
    logic [15:0]              r_count;
    t_result                  r_result;

    logic signed [PROD_W-2:0] half_r, half_i;
    logic signed [63:0]       map_r, map_i, diff, upd_r, upd_i;
    logic [63:0]              mag;

    assign half_r = (PROD_W - 1)'(r_offr >>> 1);
    assign half_i = (PROD_W - 1)'(r_offi >>> 1);
    assign map_r  = 64'(half_r) + 64'(i_cfg.center_real);
    assign map_i  = 64'(half_i) + 64'(i_cfg.center_imag);

    assign mag    = {1'b0, r_sq_rr[62:0]} + {1'b0, r_sq_ii[62:0]};
    assign diff   = r_sq_rr - r_sq_ii;
    assign upd_r  = (diff >>> FRAC_BITS) + 64'(r_cr);
    assign upd_i  = (r_pr_ri >>> (FRAC_BITS - 1)) + 64'(r_ci);

    assign o_status.at_limit  = (r_count >= i_cfg.iteration_limit);
    assign o_status.in_radius = ESC_ALWAYS || (mag <= ESC_THRESH);
    assign o_result           = r_result;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pixel) begin
            r_dr    <= $signed({3'b000, i_pixel.pixel_col, 1'b0}) - OFF_W'(IMAGE_WIDTH);
            r_di    <= $signed({3'b000, i_pixel.pixel_row, 1'b0}) - OFF_W'(IMAGE_HEIGHT);
            r_zr    <= '0;
            r_zi    <= '0;
            r_count <= '0;
        end
        if (i_cmd.map_mul) begin
            r_offr <= r_dr * $signed({1'b0, i_cfg.pixel_step});
            r_offi <= r_di * $signed({1'b0, i_cfg.pixel_step});
        end
        if (i_cmd.map_sum) begin
            r_cr <= sat32(map_r);
            r_ci <= sat32(map_i);
        end
        if (i_cmd.iter_mul) begin
            r_sq_rr <= r_zr * r_zr;
            r_sq_ii <= r_zi * r_zi;
            r_pr_ri <= r_zr * r_zi;
        end
        if (i_cmd.iter_upd) begin
            r_zr    <= sat32(upd_r);
            r_zi    <= sat32(upd_i);
            r_count <= r_count + 16'd1;
        end
        if (i_cmd.load_out) begin
            r_result.iter_count <= r_count;
            r_result.in_set     <= (r_count == i_cfg.iteration_limit);
        end
    end

endmodule

// ===== design/mbet_ctrl.sv =====
module mbet_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_pixel_valid,
    output logic              o_pixel_ready,
    output logic              o_result_valid,
    input  logic              i_result_ready,
    input  mbet_pkg::t_status i_status,
    output mbet_pkg::t_cmd    o_cmd
);
    import mbet_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP_MUL,
        ST_MAP_SUM,
        ST_ITER_MUL,
        ST_ITER_TEST,
        ST_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free       = !r_out_valid || i_result_ready;
    assign o_pixel_ready  = (r_state == ST_IDLE);
    assign o_result_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_result_ready;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_pixel_valid) begin
                    o_cmd.load_pixel = 1'b1;
                    n_state          = ST_MAP_MUL;
                end
            end
            ST_MAP_MUL: begin
                o_cmd.map_mul = 1'b1;
                n_state       = ST_MAP_SUM;
            end
            ST_MAP_SUM: begin
                o_cmd.map_sum = 1'b1;
                n_state       = ST_ITER_MUL;
            end
            ST_ITER_MUL: begin
                o_cmd.iter_mul = 1'b1;
                n_state        = ST_ITER_TEST;
            end
            ST_ITER_TEST: begin
                if (i_status.at_limit || !i_status.in_radius) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.iter_upd = 1'b1;
                    n_state        = ST_ITER_MUL;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
